[rtl/rtf_pkg.sv]
package rtf_pkg;

    localparam int unsigned CYCLES_PER_ROW = 65;
    localparam int unsigned ROWS_PER_FRAME = 263;

    localparam int unsigned CYC_W  = 7;
    localparam int unsigned LINE_W = 9;
    localparam int unsigned OFF_W  = 6;

    localparam logic [CYC_W-1:0]  CYC_LAST  = CYC_W'(CYCLES_PER_ROW - 1);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(ROWS_PER_FRAME - 1);

    localparam int unsigned BANK_DEPTH = 47;

    localparam logic [OFF_W-1:0] BANK_SIZE   = 6'h2F;
    localparam logic [OFF_W-1:0] OFF_CR1     = 6'h11;
    localparam logic [OFF_W-1:0] OFF_RASTER  = 6'h12;
    localparam logic [OFF_W-1:0] OFF_CR2     = 6'h16;
    localparam logic [OFF_W-1:0] OFF_MEMPTR  = 6'h18;
    localparam logic [OFF_W-1:0] OFF_STATUS  = 6'h19;
    localparam logic [OFF_W-1:0] OFF_ENABLE  = 6'h1A;
    localparam logic [OFF_W-1:0] OFF_COLL_SS = 6'h1E;
    localparam logic [OFF_W-1:0] OFF_COLL_SB = 6'h1F;
    localparam logic [OFF_W-1:0] OFF_BORDER  = 6'h20;
    localparam logic [OFF_W-1:0] OFF_BACK0   = 6'h21;

    localparam logic [7:0] CR1_RESET   = 8'h1B;
    localparam logic [7:0] IRQ_SET     = 8'h81;
    localparam logic [7:0] HIGH_READ   = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              eol;
        logic              wrap;
    } t_beam_stat;

    function automatic logic [7:0] bank_default(input logic [OFF_W-1:0] off);
        logic [7:0] v;
        case (off)
            OFF_CR2:    v = 8'h08;
            OFF_MEMPTR: v = 8'h14;
            OFF_BORDER: v = 8'h0E;
            OFF_BACK0:  v = 8'h06;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/rtf_if.sv]
interface rtf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    output ready);
endinterface

interface rtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       frame_done;

    modport source (output valid, output read_data, output irq_pulse, output frame_done,
                    input ready);
    modport sink   (input valid, input read_data, input irq_pulse, input frame_done,
                    output ready);
endinterface

[rtl/raster_timing_irq_register_file.sv]
// Latency: a beat's result is presented on the cycle after it is accepted.
// Throughput: one beat per cycle; ready drops only while a result is held unclaimed.
// The bank memory has one write and one registered read port, used at most once per beat.
// Reset: synchronous active low; beam counters clear, registers take power-on
// defaults at once through per-entry valid bits, no clearing pass.
module raster_timing_irq_register_file
    import rtf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rtf_in_if.sink    i_in,
    rtf_out_if.source o_out
);

    logic             acc;
    t_op              op;
    logic [OFF_W-1:0] off;
    logic             in_bank, special;
    logic             acc_tick, acc_rd, acc_wr;
    logic             mem_rd, mem_wr;
    logic             match;
    t_beam_stat       beam;

    logic [7:0] r_cr1, n_cr1;
    logic [7:0] r_rcmp, n_rcmp;
    logic [7:0] r_status, n_status;
    logic [7:0] r_enable, n_enable;
    logic [7:0] r_coll_ss, n_coll_ss;
    logic [7:0] r_coll_sb, n_coll_sb;

    logic       r_valid;
    logic       r_use_mem, n_use_mem;
    logic [7:0] r_rd, n_rd;
    logic       r_irq, r_done;
    logic [7:0] mem_q;

    assign op  = t_op'(i_in.opcode);
    assign off = i_in.address[OFF_W-1:0];
    assign acc = i_in.valid && i_in.ready;

    assign i_in.ready = !r_valid || o_out.ready;

    assign acc_tick = acc && (op == OP_TICK);
    assign acc_rd   = acc && (op == OP_READ);
    assign acc_wr   = acc && (op == OP_WRITE);

    assign in_bank = (off < BANK_SIZE);
    assign special = (off == OFF_CR1) || (off == OFF_RASTER) || (off == OFF_STATUS) ||
                     (off == OFF_ENABLE) || (off == OFF_COLL_SS) || (off == OFF_COLL_SB);

    assign mem_rd = acc_rd && in_bank && !special;
    assign mem_wr = acc_wr && in_bank && !special;

    assign match = beam.eol && (beam.line == {r_cr1[7], r_rcmp}) && r_enable[0];

    rtf_beam u_beam (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (acc_tick),
        .o_stat (beam)
    );

    rtf_bank u_bank (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(mem_rd),
        .i_wr_en(mem_wr),
        .i_addr (off),
        .i_wdata(i_in.write_data),
        .o_rdata(mem_q)
    );

    always_comb begin
        n_cr1     = r_cr1;
        n_rcmp    = r_rcmp;
        n_status  = r_status;
        n_enable  = r_enable;
        n_coll_ss = r_coll_ss;
        n_coll_sb = r_coll_sb;
        n_rd      = 8'h00;
        n_use_mem = 1'b0;
        if (acc_tick && match) begin
            n_status = r_status | IRQ_SET;
        end
        if (acc_rd) begin
            if (!in_bank) begin
                n_rd = HIGH_READ;
            end else begin
                case (off)
                    OFF_CR1:     n_rd = {beam.line[8], r_cr1[6:0]};
                    OFF_RASTER:  n_rd = beam.line[7:0];
                    OFF_STATUS: begin
                        n_rd     = r_status;
                        n_status = 8'h00;
                    end
                    OFF_ENABLE:  n_rd = r_enable;
                    OFF_COLL_SS: begin
                        n_rd      = r_coll_ss;
                        n_coll_ss = 8'h00;
                    end
                    OFF_COLL_SB: begin
                        n_rd      = r_coll_sb;
                        n_coll_sb = 8'h00;
                    end
                    default:     n_use_mem = 1'b1;
                endcase
            end
        end
        if (acc_wr) begin
            case (off)
                OFF_CR1:     n_cr1     = i_in.write_data;
                OFF_RASTER:  n_rcmp    = i_in.write_data;
                OFF_STATUS:  n_status  = r_status & ~i_in.write_data;
                OFF_ENABLE:  n_enable  = i_in.write_data;
                OFF_COLL_SS: n_coll_ss = i_in.write_data;
                OFF_COLL_SB: n_coll_sb = i_in.write_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr1     <= CR1_RESET;
            r_rcmp    <= 8'h00;
            r_status  <= 8'h00;
            r_enable  <= 8'h00;
            r_coll_ss <= 8'h00;
            r_coll_sb <= 8'h00;
            r_valid   <= 1'b0;
        end else begin
            r_cr1     <= n_cr1;
            r_rcmp    <= n_rcmp;
            r_status  <= n_status;
            r_enable  <= n_enable;
            r_coll_ss <= n_coll_ss;
            r_coll_sb <= n_coll_sb;
            if (acc) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd      <= n_rd;
            r_use_mem <= n_use_mem;
            r_irq     <= acc_tick && match;
            r_done    <= acc_tick && beam.wrap;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.read_data  = r_use_mem ? mem_q : r_rd;
    assign o_out.irq_pulse  = r_irq;
    assign o_out.frame_done = r_done;

    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.irq_pulse || o_out.frame_done)) |-> (o_out.read_data == 8'h00))
        else $error("tick result carries read data");

    a_irq_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_tick && match) |=> (r_status[7] && r_status[0]))
        else $error("raster interrupt not latched in status");

    a_wrap_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_tick && beam.wrap) |=> (beam.line == '0))
        else $error("beam did not wrap to line zero");

    a_line_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beam.line <= LINE_LAST)
        else $error("beam line beyond frame");

endmodule

[rtl/rtf_beam.sv]
module rtf_beam
    import rtf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    output t_beam_stat o_stat
);

    logic [CYC_W-1:0]  r_cycle, n_cycle;
    logic [LINE_W-1:0] r_line, n_line;

    assign o_stat.line = r_line;
    assign o_stat.eol  = (r_cycle == CYC_LAST);
    assign o_stat.wrap = o_stat.eol && (r_line == LINE_LAST);

    always_comb begin
        n_cycle = r_cycle;
        n_line  = r_line;
        if (i_adv) begin
            if (o_stat.eol) begin
                n_cycle = '0;
                n_line  = o_stat.wrap ? '0 : r_line + LINE_W'(1);
            end else begin
                n_cycle = r_cycle + CYC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle <= '0;
            r_line  <= '0;
        end else begin
            r_cycle <= n_cycle;
            r_line  <= n_line;
        end
    end

endmodule

[rtl/rtf_bank.sv]
module rtf_bank
    import rtf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  logic [OFF_W-1:0] i_addr,
    input  logic [7:0]       i_wdata,
    output logic [7:0]       o_rdata
);

    logic [7:0]            r_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld;
    logic [7:0]            r_q;
    logic [7:0]            r_dflt;
    logic                  r_q_vld;

    assign o_rdata = r_q_vld ? r_q : r_dflt;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_q    <= r_mem[i_addr];
            r_dflt <= bank_default(i_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_addr];
            end
            if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
        end
    end

endmodule

[tb/raster_timing_irq_register_file_tb.sv]
module raster_timing_irq_register_file_tb
    import rtf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_AT      = 300;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int N_DIRECTED   = 25;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
        logic       frame_done;
    } t_reply;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        known;
        t_reply      want;
    } t_row;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{OP_READ,  16'h0011, 8'h00, 1'b1, '{8'h1B, 1'b0, 1'b0}},
        '{OP_READ,  16'h0052, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0096, 8'h00, 1'b1, '{8'h08, 1'b0, 1'b0}},
        '{OP_READ,  16'h00D8, 8'h00, 1'b1, '{8'h14, 1'b0, 1'b0}},
        '{OP_READ,  16'h1020, 8'h00, 1'b1, '{8'h0E, 1'b0, 1'b0}},
        '{OP_READ,  16'hFFE1, 8'h00, 1'b1, '{8'h06, 1'b0, 1'b0}},
        '{OP_READ,  16'h0019, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h002F, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_READ,  16'hFFFF, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h002F, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h006F, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_NONE,  16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'hFFC0, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0040, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h001E, 8'h5A, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h001E, 8'h00, 1'b1, '{8'h5A, 1'b0, 1'b0}},
        '{OP_READ,  16'h001E, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h005F, 8'hA5, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h001F, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h0019, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_TICK,  16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h0011, 8'h80, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0011, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rtf_in_if  cmd_bus ();
    rtf_out_if reply_bus ();

    raster_timing_irq_register_file uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (reply_bus)
    );

    logic [7:0]        bank_shadow [BANK_DEPTH];
    logic [CYC_W-1:0]  shadow_cycle;
    logic [LINE_W-1:0] shadow_row;

    t_reply pending_replies [$];

    int send_calm      = 0;
    int recv_calm      = 0;
    int cycle_count    = 0;
    int beats_sent     = 0;
    int ticks_sent     = 0;
    int irqs_predicted = 0;
    int frame_wraps    = 0;
    int replies_taken  = 0;
    int mismatch_count = 0;
    int orphan_count   = 0;
    int report_count   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic t_reply chip_reply(t_op op, logic [15:0] addr, logic [7:0] data);
        t_reply            r;
        logic [OFF_W-1:0]  off;
        logic [LINE_W-1:0] cmp;
        r   = '0;
        off = addr[OFF_W-1:0];
        case (op)
            OP_TICK: begin
                if (shadow_cycle == CYC_LAST) begin
                    shadow_cycle = '0;
                    cmp = {bank_shadow[OFF_CR1][7], bank_shadow[OFF_RASTER]};
                    if (shadow_row == cmp && bank_shadow[OFF_ENABLE][0]) begin
                        bank_shadow[OFF_STATUS] = bank_shadow[OFF_STATUS] | IRQ_SET;
                        r.irq_pulse = 1'b1;
                    end
                    if (shadow_row == LINE_LAST) begin
                        shadow_row   = '0;
                        r.frame_done = 1'b1;
                    end else begin
                        shadow_row = shadow_row + LINE_W'(1);
                    end
                end else begin
                    shadow_cycle = shadow_cycle + CYC_W'(1);
                end
            end
            OP_READ: begin
                if (off >= BANK_SIZE) begin
                    r.read_data = HIGH_READ;
                end else begin
                    case (off)
                        OFF_CR1:    r.read_data = {shadow_row[8], bank_shadow[OFF_CR1][6:0]};
                        OFF_RASTER: r.read_data = shadow_row[7:0];
                        OFF_STATUS, OFF_COLL_SS, OFF_COLL_SB: begin
                            r.read_data      = bank_shadow[off];
                            bank_shadow[off] = '0;
                        end
                        default:    r.read_data = bank_shadow[off];
                    endcase
                end
            end
            OP_WRITE: begin
                if (off < BANK_SIZE) begin
                    if (off == OFF_STATUS) begin
                        bank_shadow[off] = bank_shadow[off] & ~data;
                    end else begin
                        bank_shadow[off] = data;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_beat(input t_op op, input logic [15:0] addr, input logic [7:0] data,
                             input logic known, input t_reply table_reply);
        int     gap;
        t_reply predicted;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= op;
        cmd_bus.address    <= addr;
        cmd_bus.write_data <= data;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        predicted = chip_reply(op, addr, data);
        pending_replies.push_back(known ? table_reply : predicted);
        beats_sent++;
        if (op == OP_TICK) ticks_sent++;
        if (predicted.irq_pulse) irqs_predicted++;
        if (predicted.frame_done) frame_wraps++;
    endtask

    task automatic poke_bus();
        logic [OFF_W-1:0] off;
        logic [7:0]       data;
        int               pick;
        t_op              op;
        case ($urandom_range(0, 7))
            0:       off = OFF_CR1;
            1:       off = OFF_RASTER;
            2:       off = OFF_STATUS;
            3:       off = OFF_ENABLE;
            4:       off = ($urandom_range(0, 1) == 0) ? OFF_COLL_SS : OFF_COLL_SB;
            5:       off = OFF_W'($urandom_range(BANK_SIZE, 63));
            default: off = OFF_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = 8'($urandom);
        endcase
        pick = $urandom_range(0, 19);
        op   = (pick < 9) ? OP_READ : (pick < 18) ? OP_WRITE : OP_NONE;
        send_beat(op, {10'($urandom), off}, data, 1'b0, '0);
    endtask

    // aim the raster compare at a nearby line, a frame edge or past the frame
    task automatic aim_compare();
        logic [LINE_W-1:0] target;
        case ($urandom_range(0, 5))
            0:       target = '0;
            1:       target = LINE_LAST;
            2:       target = LINE_W'($urandom_range(ROWS_PER_FRAME, 511));
            default: target = shadow_row + LINE_W'($urandom_range(0, 4));
        endcase
        send_beat(OP_WRITE, {10'($urandom), OFF_CR1}, {target[8], 7'($urandom)}, 1'b0, '0);
        send_beat(OP_WRITE, {10'($urandom), OFF_RASTER}, target[7:0], 1'b0, '0);
        send_beat(OP_WRITE, {10'($urandom), OFF_ENABLE},
                  {7'($urandom), 1'($urandom_range(0, 4) != 0)}, 1'b0, '0);
    endtask

    task automatic run_mix(input int tick_pct, input int min_items, input int min_wraps);
        int                n;
        int                wrap_goal;
        logic [LINE_W-1:0] last_row;
        n         = 0;
        wrap_goal = frame_wraps + min_wraps;
        last_row  = shadow_row;
        while (n < min_items || frame_wraps < wrap_goal) begin
            if (shadow_row != last_row && $urandom_range(0, 3) == 0) aim_compare();
            last_row = shadow_row;
            if ($urandom_range(0, 99) < tick_pct) begin
                send_beat(OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
                poke_bus();
            end
            n++;
        end
    endtask

    initial begin
        int     stall;
        t_reply want;
        reply_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (replies_taken == HOLD_AT) begin
                stall = LONG_HOLD;
            end else begin
                stall = draw_idle(recv_calm);
            end
            if (stall > 0) begin
                reply_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            reply_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!reply_bus.valid) @(posedge i_clk);
            if (pending_replies.size() == 0) begin
                orphan_count++;
                if (report_count < REPORT_MAX) begin
                    $display("reply %0d arrived with nothing expected: %s%02h irq %0b wrap %0b",
                             replies_taken, "rd ", reply_bus.read_data,
                             reply_bus.irq_pulse, reply_bus.frame_done);
                    report_count++;
                end
            end else begin
                want = pending_replies.pop_front();
                if (reply_bus.read_data !== want.read_data ||
                    reply_bus.irq_pulse !== want.irq_pulse ||
                    reply_bus.frame_done !== want.frame_done) begin
                    mismatch_count++;
                    if (report_count < REPORT_MAX) begin
                        $display("reply %0d: want rd %02h irq %0b wrap %0b,",
                                 replies_taken, want.read_data, want.irq_pulse,
                                 want.frame_done);
                        $display("    got rd %02h irq %0b wrap %0b",
                                 reply_bus.read_data, reply_bus.irq_pulse,
                                 reply_bus.frame_done);
                        report_count++;
                    end
                end
            end
            replies_taken++;
        end
    end

    initial begin
        cmd_bus.valid      <= 1'b0;
        cmd_bus.opcode     <= OP_NONE;
        cmd_bus.address    <= '0;
        cmd_bus.write_data <= '0;
        for (int k = 0; k < BANK_DEPTH; k++) bank_shadow[k] = '0;
        bank_shadow[OFF_CR1]    = CR1_RESET;
        bank_shadow[OFF_CR2]    = 8'h08;
        bank_shadow[OFF_MEMPTR] = 8'h14;
        bank_shadow[OFF_BORDER] = 8'h0E;
        bank_shadow[OFF_BACK0]  = 8'h06;
        shadow_cycle = '0;
        shadow_row   = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_beat(DIRECTED[k].op, DIRECTED[k].addr, DIRECTED[k].data,
                      DIRECTED[k].known, DIRECTED[k].want);
        end

        // mixed traffic, raster compare re-aimed as lines go by
        run_mix(40, RANDOM_ITEMS, 0);

        cmd_bus.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d ticks, %0d bus accesses,",
                 beats_sent, ticks_sent, beats_sent - ticks_sent);
        $display("%0d raster interrupts, %0d frame wraps, %0d replies checked",
                 irqs_predicted, frame_wraps, replies_taken);
        $display("%0d mismatches, %0d unexpected", mismatch_count, orphan_count);
        if (mismatch_count == 0 && orphan_count == 0 && pending_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
